// ===== hw/rtl/scex_pkg.sv =====
// Shared opcode and status codes for the simple core execute stage.
// No dependencies.
`default_nettype none

package scex_pkg;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_ADDI   = 5'd1,
        OP_SUB    = 5'd2,
        OP_MUL    = 5'd3,
        OP_JAL    = 5'd4,
        OP_J      = 5'd5,
        OP_BEQ    = 5'd6,
        OP_BLE    = 5'd7,
        OP_BNE    = 5'd8,
        OP_SW     = 5'd9,
        OP_LW     = 5'd10,
        OP_LW_SPM = 5'd11,
        OP_SW_SPM = 5'd12,
        OP_LA     = 5'd13,
        OP_LI     = 5'd14,
        OP_ECALL  = 5'd15,
        OP_NOP    = 5'd16
    } scex_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MEM_RANGE = 2'd1,
        ST_NO_LABEL  = 2'd2
    } scex_status_t;

    // register that mirrors the core id
    localparam logic [4:0] CID_REG = 5'd31;

    // configuration register index (paddr[2])
    localparam logic REG_CORE_ID = 1'b0;

endpackage

`default_nettype wire

// ===== hw/rtl/simple_core_execute_stage.sv =====
// Execute stage: register file, word memory, scratchpad and result register.
// Depends on scex_pkg.
//
// Channel   Handshake                    Beat contents
// issue     issue_valid / issue_stall    opcode, regs, immediate, pc, label
// result    result_valid / result_stall  result, branch, status, skip, address
// config    APB (psel/penable/pwrite)    core_id at byte address 0
//
// One instruction per cycle while the result side does not stall: the accept edge
// registers the operands (register file, word memory and scratchpad reads), and the
// edge on which the operand stage advances loads the result register, raising
// result_valid, and commits all state writes. The previous instruction's writes are
// forwarded into the one behind it. After reset both memories are cleared, with
// issue_stall high. A stalled result holds the operand stage; issue_stall rises
// once that stage is occupied too.
`default_nettype none

module simple_core_execute_stage #(
    parameter int MEM_WORDS  = 1024,
    parameter int SPM_WORDS  = 256,
    parameter int PROG_WORDS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               issue_valid,
    output logic               issue_stall,
    input  logic [4:0]         opcode,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_reg_a,
    input  logic [4:0]         src_reg_b,
    input  logic signed [31:0] immediate,
    input  logic [9:0]         instr_pc,
    input  logic [9:0]         label_target,
    input  logic               label_found,

    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] result_value,
    output logic               branch_taken,
    output logic [9:0]         next_pc,
    output logic [1:0]         status,
    output logic               skip_mode,
    output logic signed [31:0] access_address
);

    import scex_pkg::*;

    localparam int MAW       = $clog2(MEM_WORDS);
    localparam int SAW       = $clog2(SPM_WORDS);
    localparam int CLR_WORDS = (MEM_WORDS > SPM_WORDS) ? MEM_WORDS : SPM_WORDS;
    localparam int CW        = $clog2(CLR_WORDS + 1);

    localparam logic signed [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);
    localparam logic signed [31:0] SPM_LIM   = 32'(SPM_WORDS);
    localparam logic [31:0]        PROG_LIM  = 32'(PROG_WORDS);

    // storage
    logic [31:0] rf_mem   [0:31];
    logic [31:0] dmem     [0:MEM_WORDS-1];
    logic [31:0] spm      [0:SPM_WORDS-1];
    logic [31:0] rf_vld_reg;

    // configuration
    logic [3:0] core_id_reg;
    logic       cfg_wr;

    // memory clear after reset
    logic          clr_busy_reg;
    logic [CW-1:0] clr_cnt_reg;

    // operand stage
    logic              s1_valid_reg;
    logic [4:0]        s1_op_reg;
    logic [4:0]        s1_rd_reg;
    logic [4:0]        s1_rs1_reg;
    logic [4:0]        s1_rs2_reg;
    logic signed [31:0] s1_imm_reg;
    logic [9:0]        s1_pc_reg;
    logic [9:0]        s1_tgt_reg;
    logic              s1_found_reg;
    logic [31:0]       rf_a_reg;
    logic [31:0]       rf_b_reg;
    logic              rf_a_vld_reg;
    logic              rf_b_vld_reg;
    logic [31:0]       dmem_rd_reg;
    logic [31:0]       spm_rd_reg;

    // forwarding of the writes committed at the accept edge
    logic           fwd_rf_vld_reg;
    logic [4:0]     fwd_rf_addr_reg;
    logic [31:0]    fwd_rf_data_reg;
    logic           fwd_dm_vld_reg;
    logic [MAW-1:0] fwd_dm_idx_reg;
    logic [31:0]    fwd_dm_data_reg;
    logic           fwd_spm_vld_reg;
    logic [SAW-1:0] fwd_spm_idx_reg;
    logic [31:0]    fwd_spm_data_reg;

    logic skip_reg;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic               out_taken_reg;
    logic [9:0]         out_npc_reg;
    logic [1:0]         out_status_reg;
    logic               out_skip_reg;
    logic signed [31:0] out_addr_reg;

    logic accept;
    logic s1_adv;
    logic [MAW-1:0] in_word_idx;

    // execute logic
    logic [31:0]    op_a;
    logic [31:0]    op_b;
    logic           word_ok;
    logic [MAW-1:0] word_idx;
    logic [31:0]    word_ld;
    logic           spm_ok;
    logic [SAW-1:0] spm_idx;
    logic [31:0]    spm_ld;
    logic           label_ok;
    logic           cond;
    logic [31:0]    mul_lo;

    logic [31:0] ex_result;
    logic        ex_taken;
    logic [9:0]  ex_npc;
    logic [1:0]  ex_status;
    logic        ex_rf_we;
    logic [31:0] ex_rf_wd;
    logic        ex_dm_we;
    logic        ex_spm_we;
    logic [31:0] ex_addr;
    logic        ex_skip_set;

    logic rf_we;
    logic dm_st;
    logic spm_st;

    // memory write ports
    logic           dm_we;
    logic [MAW-1:0] dm_wa;
    logic [31:0]    dm_wd;
    logic           spm_we;
    logic [SAW-1:0] spm_wa;
    logic [31:0]    spm_wd;

    // ---------------------------------------------------------------- control

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign issue_stall = clr_busy_reg || (s1_valid_reg && !s1_adv);
    assign accept      = issue_valid && !issue_stall;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CORE_ID);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CORE_ID) ? {28'd0, core_id_reg} : 32'd0;

    // imm/4 toward zero: -3..-1 land on word 0
    assign in_word_idx = immediate[31] ? '0 : immediate[MAW+1:2];

    // ---------------------------------------------------------------- execute

    always_comb
    begin
        op_a = rf_a_vld_reg ? rf_a_reg : 32'd0;
        if (fwd_rf_vld_reg && fwd_rf_addr_reg == s1_rs1_reg)
        begin
            op_a = fwd_rf_data_reg;
        end
        op_b = rf_b_vld_reg ? rf_b_reg : 32'd0;
        if (fwd_rf_vld_reg && fwd_rf_addr_reg == s1_rs2_reg)
        begin
            op_b = fwd_rf_data_reg;
        end
    end

    assign word_ok  = (s1_imm_reg > -32'sd4) && (s1_imm_reg < MEM_BYTES);
    assign word_idx = s1_imm_reg[31] ? '0 : s1_imm_reg[MAW+1:2];
    assign word_ld  = (fwd_dm_vld_reg && fwd_dm_idx_reg == word_idx) ?
                      fwd_dm_data_reg : dmem_rd_reg;

    assign spm_ok  = !s1_imm_reg[31] && (s1_imm_reg < SPM_LIM);
    assign spm_idx = s1_imm_reg[SAW-1:0];
    assign spm_ld  = (fwd_spm_vld_reg && fwd_spm_idx_reg == spm_idx) ?
                     fwd_spm_data_reg : spm_rd_reg;

    assign label_ok = s1_found_reg && ({22'd0, s1_tgt_reg} < PROG_LIM);
    assign mul_lo   = op_a * op_b;

    always_comb
    begin
        ex_result   = 32'd0;
        ex_taken    = 1'b0;
        ex_npc      = 10'd0;
        ex_status   = ST_OK;
        ex_rf_we    = 1'b0;
        ex_rf_wd    = 32'd0;
        ex_dm_we    = 1'b0;
        ex_spm_we   = 1'b0;
        ex_addr     = 32'd0;
        ex_skip_set = 1'b0;
        cond        = 1'b0;
        unique case (s1_op_reg)
            OP_ADD:
            begin
                ex_result = op_a + op_b;
                ex_rf_we  = 1'b1;
            end
            OP_ADDI:
            begin
                ex_result = op_a + s1_imm_reg;
                ex_rf_we  = 1'b1;
            end
            OP_SUB:
            begin
                ex_result = op_a - op_b;
                ex_rf_we  = 1'b1;
            end
            OP_MUL:
            begin
                ex_result = mul_lo;
                ex_rf_we  = 1'b1;
            end
            OP_JAL, OP_J:
            begin
                if (label_ok)
                begin
                    ex_taken = 1'b1;
                    ex_npc   = s1_tgt_reg;
                end
                else
                begin
                    ex_status = ST_NO_LABEL;
                end
            end
            OP_BEQ, OP_BLE, OP_BNE:
            begin
                if (s1_op_reg == OP_BEQ)
                begin
                    cond = (op_a == op_b);
                end
                else if (s1_op_reg == OP_BLE)
                begin
                    cond = ($signed(op_a) <= $signed(op_b));
                end
                else
                begin
                    cond = (op_a != op_b);
                end
                if (cond)
                begin
                    if (label_ok)
                    begin
                        ex_taken = 1'b1;
                        ex_npc   = s1_tgt_reg;
                    end
                    else
                    begin
                        ex_status = ST_NO_LABEL;
                    end
                end
                else if (s1_op_reg == OP_BNE && s1_rs1_reg == CID_REG)
                begin
                    ex_skip_set = 1'b1;
                end
            end
            OP_SW, OP_LW:
            begin
                ex_addr = s1_imm_reg;
                if (!word_ok)
                begin
                    ex_status = ST_MEM_RANGE;
                end
                else if (s1_op_reg == OP_SW)
                begin
                    ex_dm_we = 1'b1;
                end
                else
                begin
                    ex_result = word_ld;
                    ex_rf_we  = 1'b1;
                end
            end
            OP_LW_SPM:
            begin
                ex_addr   = s1_imm_reg;
                ex_status = spm_ok ? ST_OK : ST_MEM_RANGE;
                ex_result = spm_ok ? spm_ld : 32'd0;
                ex_rf_we  = 1'b1;
            end
            OP_SW_SPM:
            begin
                ex_addr   = s1_imm_reg;
                ex_status = spm_ok ? ST_OK : ST_MEM_RANGE;
                ex_spm_we = spm_ok;
            end
            OP_LA:
            begin
                if (s1_found_reg)
                begin
                    ex_result = s1_imm_reg;
                    ex_rf_we  = 1'b1;
                end
                else
                begin
                    ex_status = ST_NO_LABEL;
                end
            end
            OP_LI:
            begin
                ex_result = s1_imm_reg;
                ex_rf_we  = 1'b1;
            end
            default:
            begin
                ex_result = 32'd0;
            end
        endcase
        // JAL links pc+1 but reports no value
        ex_rf_wd = ex_result;
        if (s1_op_reg == OP_JAL)
        begin
            ex_rf_we = 1'b1;
            ex_rf_wd = {21'd0, {1'b0, s1_pc_reg} + 11'd1};
        end
    end

    assign rf_we  = s1_adv && ex_rf_we && (s1_rd_reg != 5'd0);
    assign dm_st  = s1_adv && ex_dm_we;
    assign spm_st = s1_adv && ex_spm_we;

    // ---------------------------------------------------------------- memories

    always_comb
    begin
        if (clr_busy_reg)
        begin
            dm_we  = (clr_cnt_reg < CW'(MEM_WORDS));
            dm_wa  = clr_cnt_reg[MAW-1:0];
            dm_wd  = 32'd0;
            spm_we = (clr_cnt_reg < CW'(SPM_WORDS));
            spm_wa = clr_cnt_reg[SAW-1:0];
            spm_wd = 32'd0;
        end
        else
        begin
            dm_we  = dm_st;
            dm_wa  = word_idx;
            dm_wd  = op_b;
            spm_we = spm_st;
            spm_wa = spm_idx;
            spm_wd = op_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_wa] <= dm_wd;
        end
        if (spm_we)
        begin
            spm[spm_wa] <= spm_wd;
        end
        if (rf_we)
        begin
            rf_mem[s1_rd_reg] <= ex_rf_wd;
        end
        else if (cfg_wr)
        begin
            rf_mem[CID_REG] <= {28'd0, pwdata[3:0]};
        end
        if (accept)
        begin
            rf_a_reg    <= rf_mem[src_reg_a];
            rf_b_reg    <= rf_mem[src_reg_b];
            dmem_rd_reg <= dmem[in_word_idx];
            spm_rd_reg  <= spm[immediate[SAW-1:0]];
        end
    end

    // ---------------------------------------------------------------- datapath regs

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg        <= opcode;
            s1_rd_reg        <= dest_reg;
            s1_rs1_reg       <= src_reg_a;
            s1_rs2_reg       <= src_reg_b;
            s1_imm_reg       <= immediate;
            s1_pc_reg        <= instr_pc;
            s1_tgt_reg       <= label_target;
            s1_found_reg     <= label_found;
            fwd_rf_addr_reg  <= s1_rd_reg;
            fwd_rf_data_reg  <= ex_rf_wd;
            fwd_dm_idx_reg   <= word_idx;
            fwd_dm_data_reg  <= op_b;
            fwd_spm_idx_reg  <= spm_idx;
            fwd_spm_data_reg <= op_b;
        end
        if (s1_adv)
        begin
            out_value_reg  <= ex_result;
            out_taken_reg  <= ex_taken;
            out_npc_reg    <= ex_npc;
            out_status_reg <= ex_status;
            out_skip_reg   <= skip_reg | ex_skip_set;
            out_addr_reg   <= ex_addr;
        end
    end

    // ---------------------------------------------------------------- control regs

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_id_reg     <= 4'd0;
            rf_vld_reg      <= 32'd0;
            clr_busy_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            rf_a_vld_reg    <= 1'b0;
            rf_b_vld_reg    <= 1'b0;
            fwd_rf_vld_reg  <= 1'b0;
            fwd_dm_vld_reg  <= 1'b0;
            fwd_spm_vld_reg <= 1'b0;
            skip_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                core_id_reg <= pwdata[3:0];
            end

            if (rf_we)
            begin
                rf_vld_reg[s1_rd_reg] <= 1'b1;
            end
            else if (cfg_wr)
            begin
                rf_vld_reg[CID_REG] <= 1'b1;
            end

            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CLR_WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                rf_a_vld_reg    <= rf_vld_reg[src_reg_a];
                rf_b_vld_reg    <= rf_vld_reg[src_reg_b];
                // writes landing on this edge are not yet in the read data
                fwd_rf_vld_reg  <= rf_we;
                fwd_dm_vld_reg  <= dm_st;
                fwd_spm_vld_reg <= spm_st;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                skip_reg      <= skip_reg | ex_skip_set;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid   = out_valid_reg;
    assign result_value   = out_value_reg;
    assign branch_taken   = out_taken_reg;
    assign next_pc        = out_npc_reg;
    assign status         = out_status_reg;
    assign skip_mode      = out_skip_reg;
    assign access_address = out_addr_reg;

endmodule

`default_nettype wire

// ===== dv/scex_result_checker.sv =====
// Result checker for simple_core_execute_stage: tracks the core's architectural state,
// predicts each retire beat and compares it with the result channel.
// Depends on scex_pkg.
`timescale 1ns / 1ps

module scex_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        issue_valid,
    input  logic        issue_stall,
    input  logic [4:0]  opcode,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src_reg_a,
    input  logic [4:0]  src_reg_b,
    input  logic [31:0] immediate,
    input  logic [9:0]  instr_pc,
    input  logic [9:0]  label_target,
    input  logic        label_found,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] result_value,
    input  logic        branch_taken,
    input  logic [9:0]  next_pc,
    input  logic [1:0]  status,
    input  logic        skip_mode,
    input  logic [31:0] access_address,
    output int          fail_count,
    output int          pending,
    output int          beats_checked
);

    import scex_pkg::*;

    localparam int MEM_WORDS  = 1024;
    localparam int SPM_WORDS  = 256;
    localparam int WORD_BYTES = 4;

    typedef struct packed {
        logic [31:0] value;
        logic        taken;
        logic [9:0]  npc;
        logic [1:0]  st;
        logic        skip;
        logic [31:0] addr;
    } retire_beat_t;

    logic [31:0]  regs [32];
    logic [31:0]  dmem [MEM_WORDS];
    logic [31:0]  spm  [SPM_WORDS];
    logic         skip_flag;
    logic [3:0]   core_id;
    retire_beat_t predicted_retire_q [$];
    int           fails;
    int           nchecked;

    function automatic void write_reg(logic [4:0] r, logic [31:0] v);
        if (r != 5'd0)
            regs[r] = v;
    endfunction

    function automatic retire_beat_t execute_instr(logic [4:0] op, logic [4:0] rd,
                                                   logic [4:0] rs1, logic [4:0] rs2,
                                                   logic [31:0] imm, logic [9:0] pc,
                                                   logic [9:0] tgt, logic found);
        retire_beat_t r;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         jump;
        logic         cond;
        longint       idx;
        a = regs[rs1];
        b = regs[rs2];
        r = '0;
        r.st = ST_OK;
        jump = 1'b0;
        cond = 1'b0;
        case (op)
            OP_ADD:  begin r.value = a + b;   write_reg(rd, r.value); end
            OP_ADDI: begin r.value = a + imm; write_reg(rd, r.value); end
            OP_SUB:  begin r.value = a - b;   write_reg(rd, r.value); end
            OP_MUL:  begin r.value = a * b;   write_reg(rd, r.value); end
            OP_JAL:
            begin
                // link is written even when the label is missing
                write_reg(rd, 32'(pc) + 32'd1);
                jump = 1'b1;
            end
            OP_J: jump = 1'b1;
            OP_BEQ, OP_BLE, OP_BNE:
            begin
                if (op == OP_BEQ)
                    cond = (a == b);
                else if (op == OP_BLE)
                    cond = ($signed(a) <= $signed(b));
                else
                    cond = (a != b);
                jump = cond;
                if (op == OP_BNE && !cond && rs1 == CID_REG)
                    skip_flag = 1'b1;
            end
            OP_SW, OP_LW:
            begin
                // word index truncates toward zero, so -3..-1 still hit word 0
                idx = longint'($signed(imm)) / WORD_BYTES;
                r.addr = imm;
                if (idx >= 0 && idx < MEM_WORDS)
                begin
                    if (op == OP_SW)
                        dmem[idx] = b;
                    else
                    begin
                        r.value = dmem[idx];
                        write_reg(rd, r.value);
                    end
                end
                else
                    r.st = ST_MEM_RANGE;
            end
            OP_LW_SPM, OP_SW_SPM:
            begin
                idx = longint'($signed(imm));
                r.addr = imm;
                if (idx < 0 || idx >= SPM_WORDS)
                begin
                    r.st = ST_MEM_RANGE;
                    // out-of-range scratchpad load still writes zero
                    if (op == OP_LW_SPM)
                        write_reg(rd, 32'd0);
                end
                else if (op == OP_SW_SPM)
                    spm[idx] = b;
                else
                begin
                    r.value = spm[idx];
                    write_reg(rd, r.value);
                end
            end
            OP_LA:
            begin
                if (found)
                begin
                    r.value = imm;
                    write_reg(rd, imm);
                end
                else
                    r.st = ST_NO_LABEL;
            end
            OP_LI: begin r.value = imm; write_reg(rd, imm); end
            default: ;
        endcase
        if (jump)
        begin
            if (found)
            begin
                r.taken = 1'b1;
                r.npc = tgt;
            end
            else
                r.st = ST_NO_LABEL;
        end
        r.skip = skip_flag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        retire_beat_t got;
        retire_beat_t exp_beat;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                regs[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++)
                dmem[i] = '0;
            for (int i = 0; i < SPM_WORDS; i++)
                spm[i] = '0;
            skip_flag = 1'b0;
            core_id = 4'd0;
            predicted_retire_q.delete();
            fails = 0;
            nchecked = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_CORE_ID)
            begin
                if (pwrite)
                begin
                    core_id = pwdata[3:0];
                    regs[CID_REG] = {28'd0, pwdata[3:0]};
                end
                else if (prdata !== {28'd0, core_id})
                begin
                    fails++;
                    $display("%0t: core_id read mismatch: exp %0d got %h", $time, core_id,
                             prdata);
                end
            end
            // result beats come from earlier issues, so check before predicting
            if (result_valid && !result_stall)
            begin
                got = '{result_value, branch_taken, next_pc, status, skip_mode,
                        access_address};
                if (predicted_retire_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: result beat with nothing outstanding: value=%h taken=%b",
                             $time, result_value, branch_taken);
                end
                else
                begin
                    exp_beat = predicted_retire_q.pop_front();
                    nchecked++;
                    if (got !== exp_beat)
                    begin
                        fails++;
                        $display("%0t: beat %0d mismatch", $time, nchecked);
                        $display("    exp value=%h taken=%b npc=%0d st=%0d skip=%b addr=%h",
                                 exp_beat.value, exp_beat.taken, exp_beat.npc,
                                 exp_beat.st, exp_beat.skip, exp_beat.addr);
                        $display("    got value=%h taken=%b npc=%0d st=%0d skip=%b addr=%h",
                                 got.value, got.taken, got.npc, got.st, got.skip,
                                 got.addr);
                    end
                end
            end
            if (issue_valid && !issue_stall)
                predicted_retire_q.insert(predicted_retire_q.size(),
                                          execute_instr(opcode, dest_reg, src_reg_a,
                                                        src_reg_b, immediate, instr_pc,
                                                        label_target, label_found));
        end
        fail_count <= fails;
        pending <= predicted_retire_q.size();
        beats_checked <= nchecked;
    end

endmodule

// ===== dv/tb.sv =====
// Top of the execute stage testbench: clock, reset, APB setup, instruction stimulus
// and the result-side stall pattern. Depends on scex_pkg, simple_core_execute_stage
// and scex_result_checker.
`timescale 1ns / 1ps

module tb;
    import scex_pkg::*;

    localparam int ITEMS_PER_PHASE = 450;
    localparam int HOLD_CYCLES     = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        issue_valid, issue_stall;
    logic [4:0]  opcode, dest_reg, src_reg_a, src_reg_b;
    logic [31:0] immediate;
    logic [9:0]  instr_pc, label_target;
    logic        label_found;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] result_value, access_address;
    logic        branch_taken, skip_mode;
    logic [9:0]  next_pc;
    logic [1:0]  status;

    int fail_count, pending, beats_checked;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int n_sent = 0;

    always #10 clk = ~clk;

    simple_core_execute_stage uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .issue_valid(issue_valid), .issue_stall(issue_stall),
        .opcode(opcode), .dest_reg(dest_reg), .src_reg_a(src_reg_a),
        .src_reg_b(src_reg_b), .immediate(immediate), .instr_pc(instr_pc),
        .label_target(label_target), .label_found(label_found),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_value(result_value), .branch_taken(branch_taken), .next_pc(next_pc),
        .status(status), .skip_mode(skip_mode), .access_address(access_address)
    );

    scex_result_checker result_chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .issue_valid(issue_valid), .issue_stall(issue_stall),
        .opcode(opcode), .dest_reg(dest_reg), .src_reg_a(src_reg_a),
        .src_reg_b(src_reg_b), .immediate(immediate), .instr_pc(instr_pc),
        .label_target(label_target), .label_found(label_found),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_value(result_value), .branch_taken(branch_taken), .next_pc(next_pc),
        .status(status), .skip_mode(skip_mode), .access_address(access_address),
        .fail_count(fail_count), .pending(pending), .beats_checked(beats_checked)
    );

    // result side: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_reqs)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_instr(input logic [4:0] op, input logic [4:0] rd,
                              input logic [4:0] ra, input logic [4:0] rb,
                              input logic [31:0] imm, input logic [9:0] pc,
                              input logic [9:0] tgt, input logic found);
        while ($urandom_range(99) < send_idle_pct)
        begin
            issue_valid <= 1'b0;
            @(posedge clk);
        end
        issue_valid <= 1'b1;
        opcode <= op;
        dest_reg <= rd;
        src_reg_a <= ra;
        src_reg_b <= rb;
        immediate <= imm;
        instr_pc <= pc;
        label_target <= tgt;
        label_found <= found;
        do @(posedge clk); while (issue_stall);
        n_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_CORE_ID, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // stop issuing, then wait until every issued beat has come back
    task automatic wait_drained();
        issue_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [4:0] pick_reg();
        // mostly a small pool so back-to-back dependencies are common
        if ($urandom_range(3) != 0)
            return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic send_random();
        logic [4:0]  op;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [31:0] imm;
        int          sel;
        if ($urandom_range(99) < 6)
            op = 5'($urandom_range(17, 31));
        else
            op = 5'($urandom_range(0, 16));
        imm = $urandom();
        sel = $urandom_range(9);
        ra = pick_reg();
        rb = pick_reg();
        case (op)
            OP_SW, OP_LW:
            begin
                if (sel < 7)
                    imm = $urandom_range(0, 255);
                else if (sel == 7)
                    imm = $urandom_range(4088, 4100);
                else if (sel == 8)
                    imm = 32'd0 - 32'($urandom_range(0, 8));
            end
            OP_LW_SPM, OP_SW_SPM:
            begin
                if (sel < 7)
                    imm = $urandom_range(0, 31);
                else if (sel == 7)
                    imm = $urandom_range(250, 260);
                else if (sel == 8)
                    imm = 32'd0 - 32'($urandom_range(1, 4));
            end
            OP_LI, OP_ADDI, OP_LA:
                if (sel < 5)
                    imm = 32'($urandom_range(0, 16)) - 32'd8;
            OP_BEQ, OP_BLE, OP_BNE:
            begin
                if (sel < 3)
                    rb = ra;
                if (op == OP_BNE && sel >= 7)
                    ra = CID_REG;
            end
            default: ;
        endcase
        send_instr(op, pick_reg(), ra, rb, imm, 10'($urandom()), 10'($urandom()),
                   $urandom_range(9) != 0);
    endtask

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [3:0] cid;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        issue_valid = 1'b0;
        opcode = OP_NOP;
        dest_reg = '0;
        src_reg_a = '0;
        src_reg_b = '0;
        immediate = '0;
        instr_pc = '0;
        label_target = '0;
        label_found = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset core id, arithmetic wrap, register zero, jumps and memory edges
        apb_access(1'b0, 32'd0);
        send_instr(OP_LI,   5'd1, 5'd0, 5'd0, 32'h7fff_ffff, 10'd0, 10'd0, 1'b1);
        send_instr(OP_LI,   5'd2, 5'd0, 5'd0, 32'h8000_0000, 10'd1, 10'd0, 1'b0);
        send_instr(OP_ADD,  5'd3, 5'd1, 5'd2, 32'd0, 10'd2, 10'd0, 1'b1);
        send_instr(OP_ADDI, 5'd4, 5'd1, 5'd0, 32'd1, 10'd3, 10'd0, 1'b1);
        send_instr(OP_SUB,  5'd5, 5'd2, 5'd1, 32'd0, 10'd4, 10'd0, 1'b1);
        send_instr(OP_MUL,  5'd6, 5'd1, 5'd1, 32'd0, 10'd5, 10'd0, 1'b1);
        send_instr(OP_LI,   5'd0, 5'd0, 5'd0, 32'd5, 10'd6, 10'd0, 1'b1);
        send_instr(OP_ADD,  5'd7, 5'd0, 5'd0, 32'd0, 10'd7, 10'd0, 1'b1);
        // link from the last pc with no label
        send_instr(OP_JAL,  5'd8, 5'd0, 5'd0, 32'd0, 10'd1023, 10'd1023, 1'b0);
        send_instr(OP_J,    5'd0, 5'd0, 5'd0, 32'd0, 10'd9, 10'd1023, 1'b1);
        send_instr(OP_BEQ,  5'd0, 5'd1, 5'd1, 32'd0, 10'd10, 10'd5, 1'b0);
        send_instr(OP_BLE,  5'd0, 5'd2, 5'd1, 32'd0, 10'd11, 10'd0, 1'b1);
        send_instr(OP_BLE,  5'd0, 5'd1, 5'd2, 32'd0, 10'd12, 10'd3, 1'b1);
        send_instr(OP_SW,   5'd0, 5'd0, 5'd1, 32'd4092, 10'd13, 10'd0, 1'b1);
        send_instr(OP_LW,   5'd9, 5'd0, 5'd0, 32'd4095, 10'd14, 10'd0, 1'b1);
        send_instr(OP_LW,   5'd9, 5'd0, 5'd0, 32'd4096, 10'd15, 10'd0, 1'b1);
        send_instr(OP_LW,   5'd9, 5'd0, 5'd0, 32'hffff_fffd, 10'd16, 10'd0, 1'b1);
        send_instr(OP_LW,   5'd9, 5'd0, 5'd0, 32'hffff_fffc, 10'd17, 10'd0, 1'b1);
        send_instr(OP_SW_SPM, 5'd0, 5'd0, 5'd2, 32'd255, 10'd18, 10'd0, 1'b1);
        send_instr(OP_LW_SPM, 5'd10, 5'd0, 5'd0, 32'd255, 10'd19, 10'd0, 1'b1);
        send_instr(OP_LW_SPM, 5'd10, 5'd0, 5'd0, 32'd256, 10'd20, 10'd0, 1'b1);
        send_instr(OP_LA,   5'd11, 5'd0, 5'd0, 32'd64, 10'd21, 10'd0, 1'b0);
        send_instr(OP_LA,   5'd11, 5'd0, 5'd0, 32'h8000_0000, 10'd22, 10'd0, 1'b1);
        send_instr(OP_ECALL, 5'd12, 5'd1, 5'd2, 32'hffff_ffff, 10'd23, 10'd7, 1'b1);
        send_instr(OP_NOP,  5'd12, 5'd1, 5'd2, 32'd1, 10'd24, 10'd7, 1'b1);
        send_instr(5'd31,   5'd12, 5'd1, 5'd2, 32'd1, 10'd25, 10'd7, 1'b1);
        // taken BNE on r31 leaves skip clear, the not-taken one sets it
        send_instr(OP_BNE,  5'd0, 5'd31, 5'd1, 32'd0, 10'd26, 10'd512, 1'b1);
        send_instr(OP_BNE,  5'd0, 5'd31, 5'd0, 32'd0, 10'd27, 10'd512, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0: cid = 4'd15;
                1: cid = 4'd0;
                2: cid = 4'($urandom_range(1, 14));
                default: cid = 4'($urandom_range(0, 15));
            endcase
            apb_access(1'b1, {28'($urandom()), cid});
            apb_access(1'b0, 32'd0);
            send_idle_pct <= (ph == 1) ? 46 : (ph == 3 ? 31 : 0);
            stall_pct <= (ph == 2) ? 46 : (ph == 3 ? 31 : 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 0 && i == 150)
                    hold_reqs <= hold_reqs + 1;
                send_random();
            end
        end
        stall_pct <= 0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d instructions (directed edges, then random over four core ids),",
                 n_sent);
        $display("with issue gaps, result stalls and one long hold-off; %0d beats checked.",
                 beats_checked);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/scex_pkg.sv
hw/rtl/simple_core_execute_stage.sv
dv/scex_result_checker.sv
dv/tb.sv
